// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// combinational property checked at every rising clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/ctt_pkg.sv -----
`timescale 1ns / 1ps

package ctt_pkg;

  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;

  typedef struct packed {
    logic inside_quotes;
    logic cell_nonempty;
    logic starts_with_quote;
    logic ends_with_quote;
  } cell_state_t;

  typedef struct packed {
    logic       lead_quote;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       close_quote;
    logic       cell_end;
    logic       row_end;
  } result_t;

endpackage

// ----- hw/rtl/csv_cell_tokenizer.sv -----
`timescale 1ns / 1ps
// Channel   Dir  tdata         tuser                                   tlast
// s_axis    in   [7:0] byte    -                                       -
// m_axis    out  [7:0] data    [0] lead_q [1] valid [2] close_q [3] cell_end  row_end
//
// One byte per clock while m_axis accepts; each byte is held in the input register, its result in the result register.
// Reset is asynchronous, active low, and clears the quote and cell state.
// A stall on m_axis holds both registers; s_axis tready drops once both are full.

module csv_cell_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic [3:0] m_axis_tuser_o,   // [0] lead_quote [1] byte_valid [2] close_quote [3] cell_end
  output logic       m_axis_tlast_o    // row_end
);

  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_byte;
  logic             step;
  ctt_pkg::result_t res;
  ctt_pkg::result_t res_q;

  ctt_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .byte_i  (s_axis_tdata_i),
    .valid_o (in_valid),
    .ready_i (in_ready),
    .byte_o  (in_byte)
  );

  assign step = in_valid && in_ready;

  ctt_cell_logic u_cell_logic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte),
    .result_o (res)
  );

  ctt_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid),
    .ready_o  (in_ready),
    .result_i (res),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (res_q)
  );

  assign m_axis_tdata_o = res_q.data_byte;
  assign m_axis_tuser_o = {res_q.cell_end, res_q.close_quote, res_q.byte_valid, res_q.lead_quote};
  assign m_axis_tlast_o = res_q.row_end;

endmodule

// ----- hw/rtl/ctt_in_reg.sv -----
`timescale 1ns / 1ps

module ctt_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- hw/rtl/ctt_cell_logic.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctt_cell_logic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output ctt_pkg::result_t result_o
);

  ctt_pkg::cell_state_t state_q;
  ctt_pkg::cell_state_t state_d;
  ctt_pkg::result_t     res;
  logic                 is_comma;
  logic                 is_newline;
  logic                 is_quote;

  assign is_comma   = (byte_i == ctt_pkg::CHAR_COMMA);
  assign is_newline = (byte_i == ctt_pkg::CHAR_NEWLINE);
  assign is_quote   = (byte_i == ctt_pkg::CHAR_QUOTE);

  always_comb begin
    state_d = state_q;
    res     = '0;
    if (state_q.inside_quotes) begin
      res.byte_valid          = 1'b1;
      res.data_byte           = byte_i;
      state_d.cell_nonempty   = 1'b1;
      state_d.ends_with_quote = is_quote;
      state_d.inside_quotes   = !is_quote;
    end else if (is_comma || is_newline) begin
      res.close_quote = state_q.cell_nonempty && state_q.starts_with_quote &&
                        !state_q.ends_with_quote;
      res.cell_end    = 1'b1;
      res.row_end     = is_newline;
      state_d.cell_nonempty     = 1'b0;
      state_d.starts_with_quote = 1'b0;
      state_d.ends_with_quote   = 1'b0;
    end else if (is_quote) begin
      res.byte_valid = 1'b1;
      res.data_byte  = byte_i;
      if (!state_q.cell_nonempty) begin
        state_d.starts_with_quote = 1'b1;
      end
      state_d.cell_nonempty   = 1'b1;
      state_d.ends_with_quote = 1'b1;
      state_d.inside_quotes   = 1'b1;
    end else begin
      if (!state_q.cell_nonempty) begin
        res.lead_quote            = 1'b1;
        state_d.starts_with_quote = 1'b1;
      end
      res.byte_valid          = 1'b1;
      res.data_byte           = byte_i;
      state_d.cell_nonempty   = 1'b1;
      state_d.ends_with_quote = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign result_o = res;

  `ASSERT_NEXT(a_cell_end_clears, clk_i, rst_ni, step_i && res.cell_end, !state_q.cell_nonempty && !state_q.inside_quotes)
  `ASSERT_NEXT(a_quote_opens, clk_i, rst_ni, step_i && is_quote && !state_q.inside_quotes, state_q.inside_quotes && state_q.ends_with_quote)
  `ASSERT_ALWAYS(a_boundary_no_data, clk_i, rst_ni, !res.cell_end || (!res.byte_valid && res.data_byte == 8'h00))
  `ASSERT_ALWAYS(a_row_implies_cell, clk_i, rst_ni, !res.row_end || res.cell_end)

endmodule

// ----- hw/rtl/ctt_out_reg.sv -----
`timescale 1ns / 1ps

module ctt_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  ctt_pkg::result_t result_i,
  output logic             valid_o,
  input  logic             ready_i,
  output ctt_pkg::result_t result_o
);

  logic             valid_q;
  logic             valid_d;
  ctt_pkg::result_t result_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
